// ===== hw/rtl/sccm_pkg.sv =====
`default_nettype none
package sccm_pkg;

    // Field widths.
    localparam int unsigned COORD_W  = 24;
    localparam int unsigned RAD_W    = 17;
    localparam int unsigned SLOT_W   = 4;
    localparam int unsigned COUNT_W  = 5;

    // Datapath widths: exact difference, exact square, exact sum, root, gap.
    localparam int unsigned DIFF_W   = COORD_W + 1;
    localparam int unsigned SQ_W     = 2 * COORD_W + 1;
    localparam int unsigned SUM_W    = SQ_W + 1;
    localparam int unsigned ROOT_W   = SUM_W / 2;
    localparam int unsigned RADSUM_W = RAD_W + 1;
    localparam int unsigned GAP_W    = ROOT_W + 2;

    localparam int unsigned MAX_SPHERES_DEF = 16;
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(14);

    localparam longint FIELD_MAX = 64'sd8388607;
    localparam longint FIELD_MIN = -64'sd8388608;
    localparam longint EMPTY_CLEARANCE = 64'sd10000 * 64'sd65536;
    // Saturation is monotone, so the empty value may be clipped up front.
    localparam longint LEAST_INIT =
        (EMPTY_CLEARANCE > FIELD_MAX) ? FIELD_MAX : EMPTY_CLEARANCE;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic                      action;
        logic [SLOT_W-1:0]         slot;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [RAD_W-1:0]          radius;
        logic                      restart_min;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_clearance;
        logic signed [COORD_W-1:0] overall_clearance;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [RAD_W-1:0]          radius;
    } t_sphere;

    // Control that travels alongside each slot through the datapath.
    typedef struct packed {
        logic                valid;
        logic                last;
        logic [RADSUM_W-1:0] radsum;
    } t_tag;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

// ===== hw/rtl/sccm_ram.sv =====
`default_nettype none
module sccm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== hw/rtl/sccm_sqrt_cell.sv =====
`default_nettype none
// One cell of the square-root chain: settles one root bit and hands the
// remainder, the partial root and the slot tag to the next cell.
module sccm_sqrt_cell #(
    parameter int unsigned BIT = 0
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire sccm_pkg::t_tag                i_tag,
    input  wire logic [sccm_pkg::SUM_W-1:0]    i_rem,
    input  wire logic [sccm_pkg::ROOT_W-1:0]   i_root,
    output sccm_pkg::t_tag                     o_tag,
    output logic      [sccm_pkg::SUM_W-1:0]    o_rem,
    output logic      [sccm_pkg::ROOT_W-1:0]   o_root
);

    logic [sccm_pkg::SUM_W-1:0]  w_trial;
    logic                        w_take;
    sccm_pkg::t_tag              r_tag;
    logic [sccm_pkg::SUM_W-1:0]  r_rem;
    logic [sccm_pkg::ROOT_W-1:0] r_root;

    always_comb begin
        w_trial = (sccm_pkg::SUM_W'(i_root) << (BIT + 1))
                | (sccm_pkg::SUM_W'(1) << (2 * BIT));
        w_take  = (i_rem >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.valid <= 1'b0;
        end else begin
            r_tag.valid <= i_tag.valid;
        end
        r_tag.last   <= i_tag.last;
        r_tag.radsum <= i_tag.radsum;
        r_rem        <= w_take ? (i_rem - w_trial) : i_rem;
        r_root       <= w_take ? (i_root | (sccm_pkg::ROOT_W'(1) << BIT)) : i_root;
    end

    assign o_tag  = r_tag;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule
`default_nettype wire

// ===== hw/rtl/sphere_clearance_minimum_top.sv =====
`default_nettype none
// Obstacle sphere clearance. Load items (action 0) write one obstacle sphere,
// a centre and a radius, into a slot of a table of MAX_SPHERES entries; a load
// gives no result, and a slot at or above MAX_SPHERES is ignored. A query item
// (action 1) brings a robot point and its radius and gives one result item: the
// least surface gap to the first sphere_count slots (clamped to MAX_SPHERES)
// and the running least gap since the last query with restart_min set. A query
// reads one slot per cycle from the table into a datapath of difference, square
// and sum stages followed by a chain of square-root cells, one cell per root bit
// (25 cells). When no slot is active, the point clearance is 10000 m saturated
// to the top of the field. A new item is taken only when the previous query has
// finished; loads may be taken while a result waits at the output register.
// Query only slots that have been loaded since reset. sphere_count is written
// through i_cfg_we and i_cfg_wdata and should change only while idle.
module sphere_clearance_minimum_top #(
    parameter int unsigned MAX_SPHERES = sccm_pkg::MAX_SPHERES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire sccm_pkg::t_in_item            i_in_item,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output sccm_pkg::t_out_item                o_out_item,
    input  wire logic                          i_cfg_we,
    input  wire logic [sccm_pkg::COUNT_W-1:0]  i_cfg_wdata
);

    localparam int unsigned AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam int unsigned CW = $clog2(MAX_SPHERES + 1);
    localparam int unsigned SPH_W = $bits(sccm_pkg::t_sphere);
    localparam int unsigned NCELL = sccm_pkg::ROOT_W;

    // Configuration and control state.
    logic [sccm_pkg::COUNT_W-1:0] r_count;
    sccm_pkg::t_state             r_state, n_state;
    logic [CW-1:0]                r_cnt, n_cnt;
    logic [CW-1:0]                w_active;
    logic                         w_accept, w_load, w_query;
    logic                         w_issue, w_issue_last, w_fire;

    // The query point, held while its slots are walked.
    logic signed [sccm_pkg::COORD_W-1:0] r_px, r_py, r_pz;
    logic [sccm_pkg::RAD_W-1:0]          r_prad;
    logic                                r_restart;

    // Table and datapath stages.
    sccm_pkg::t_sphere              w_wsph, w_rsph;
    logic [SPH_W-1:0]               w_rdata;
    sccm_pkg::t_tag                 r_t0, r_t1, r_t2, r_t3;
    logic [sccm_pkg::DIFF_W-1:0]    r_dx, r_dy, r_dz;
    logic [sccm_pkg::SQ_W-1:0]      r_sx, r_sy, r_sz;
    logic [sccm_pkg::SUM_W-1:0]     r_sum;
    sccm_pkg::t_tag                 w_ctag  [NCELL+1];
    logic [sccm_pkg::SUM_W-1:0]     w_crem  [NCELL+1];
    logic [sccm_pkg::ROOT_W-1:0]    w_croot [NCELL+1];
    logic signed [sccm_pkg::GAP_W-1:0] w_gap;
    logic signed [sccm_pkg::GAP_W-1:0] r_least;

    // Result.
    logic                                r_out_valid;
    sccm_pkg::t_out_item                 r_out_item;
    logic signed [sccm_pkg::COORD_W-1:0] r_running;
    logic signed [sccm_pkg::COORD_W-1:0] w_point;

    function automatic logic [sccm_pkg::DIFF_W-1:0] abs_diff(
        input logic signed [sccm_pkg::COORD_W-1:0] a,
        input logic signed [sccm_pkg::COORD_W-1:0] b
    );
        logic signed [sccm_pkg::DIFF_W-1:0] d;
        d = {a[sccm_pkg::COORD_W-1], a} - {b[sccm_pkg::COORD_W-1], b};
        return d[sccm_pkg::DIFF_W-1] ? sccm_pkg::DIFF_W'(-d) : sccm_pkg::DIFF_W'(d);
    endfunction

    // Handshake and decode.
    assign o_in_ready = (r_state == sccm_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_load     = w_accept && (i_in_item.action == sccm_pkg::ACT_LOAD);
    assign w_query    = w_accept && (i_in_item.action == sccm_pkg::ACT_QUERY);
    assign w_active   = (32'(r_count) > MAX_SPHERES) ? CW'(MAX_SPHERES) : CW'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= sccm_pkg::COUNT_RESET;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    // Sequencer: issues one slot per cycle (none when no slot is active), then waits for the last
    // one to leave the root chain, then hands the result to the output register once it is free.
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        w_issue      = 1'b0;
        w_issue_last = 1'b0;
        w_fire       = 1'b0;
        unique case (r_state)
            sccm_pkg::ST_IDLE: begin
                if (w_query) begin
                    n_cnt   = '0;
                    n_state = (w_active == '0) ? sccm_pkg::ST_DONE : sccm_pkg::ST_ISSUE;
                end
            end
            sccm_pkg::ST_ISSUE: begin
                w_issue      = 1'b1;
                w_issue_last = (r_cnt == w_active - CW'(1));
                n_cnt        = r_cnt + CW'(1);
                if (w_issue_last) begin
                    n_state = sccm_pkg::ST_DRAIN;
                end
            end
            sccm_pkg::ST_DRAIN: begin
                if (w_ctag[NCELL].valid && w_ctag[NCELL].last) begin
                    n_state = sccm_pkg::ST_DONE;
                end
            end
            sccm_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_fire  = 1'b1;
                    n_state = sccm_pkg::ST_IDLE;
                end
            end
            default: n_state = sccm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sccm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt <= n_cnt;
        if (w_query) begin
            r_px      <= i_in_item.pos_x;
            r_py      <= i_in_item.pos_y;
            r_pz      <= i_in_item.pos_z;
            r_prad    <= i_in_item.radius;
            r_restart <= i_in_item.restart_min;
        end
    end

    // Obstacle table.
    always_comb begin
        w_wsph.x      = i_in_item.pos_x;
        w_wsph.y      = i_in_item.pos_y;
        w_wsph.z      = i_in_item.pos_z;
        w_wsph.radius = i_in_item.radius;
    end

    sccm_ram #(
        .WIDTH (SPH_W),
        .DEPTH (MAX_SPHERES),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_load && (32'(i_in_item.slot) < MAX_SPHERES)),
        .i_waddr (AW'(i_in_item.slot)),
        .i_wdata (w_wsph),
        .i_raddr (AW'(r_cnt)),
        .o_rdata (w_rdata)
    );

    assign w_rsph = w_rdata;

    // Front end: difference, square and sum stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t0.valid <= 1'b0;
            r_t1.valid <= 1'b0;
            r_t2.valid <= 1'b0;
            r_t3.valid <= 1'b0;
        end else begin
            r_t0.valid <= w_issue;
            r_t1.valid <= r_t0.valid;
            r_t2.valid <= r_t1.valid;
            r_t3.valid <= r_t2.valid;
        end
        r_t0.last   <= w_issue_last;
        r_t0.radsum <= '0;
        r_t1.last   <= r_t0.last;
        r_t1.radsum <= sccm_pkg::RADSUM_W'(r_prad) + sccm_pkg::RADSUM_W'(w_rsph.radius);
        r_t2.last   <= r_t1.last;
        r_t2.radsum <= r_t1.radsum;
        r_t3.last   <= r_t2.last;
        r_t3.radsum <= r_t2.radsum;
        r_dx        <= abs_diff(r_px, w_rsph.x);
        r_dy        <= abs_diff(r_py, w_rsph.y);
        r_dz        <= abs_diff(r_pz, w_rsph.z);
        r_sx        <= sccm_pkg::SQ_W'(r_dx * r_dx);
        r_sy        <= sccm_pkg::SQ_W'(r_dy * r_dy);
        r_sz        <= sccm_pkg::SQ_W'(r_dz * r_dz);
        r_sum       <= sccm_pkg::SUM_W'(r_sx) + sccm_pkg::SUM_W'(r_sy) + sccm_pkg::SUM_W'(r_sz);
    end

    // Square-root chain, most significant root bit first.
    assign w_ctag[0]  = r_t3;
    assign w_crem[0]  = r_sum;
    assign w_croot[0] = '0;

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        sccm_sqrt_cell #(
            .BIT (NCELL - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tag   (w_ctag[k]),
            .i_rem   (w_crem[k]),
            .i_root  (w_croot[k]),
            .o_tag   (w_ctag[k+1]),
            .o_rem   (w_crem[k+1]),
            .o_root  (w_croot[k+1])
        );
    end

    // Gap and least-gap accumulation.
    assign w_gap = $signed({2'b00, w_croot[NCELL]})
                 - $signed(sccm_pkg::GAP_W'(w_ctag[NCELL].radsum));

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_least <= sccm_pkg::GAP_W'(sccm_pkg::LEAST_INIT);
        end else if (w_ctag[NCELL].valid && (w_gap < r_least)) begin
            r_least <= w_gap;
        end
    end

    // The gap cannot fall far below zero, yet both ends are clipped.
    always_comb begin
        if (64'(r_least) > sccm_pkg::FIELD_MAX) begin
            w_point = sccm_pkg::COORD_W'(sccm_pkg::FIELD_MAX);
        end else if (64'(r_least) < sccm_pkg::FIELD_MIN) begin
            w_point = sccm_pkg::COORD_W'(sccm_pkg::FIELD_MIN);
        end else begin
            w_point = sccm_pkg::COORD_W'(r_least);
        end
    end

    // Output register and running minimum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_running   <= sccm_pkg::COORD_W'(sccm_pkg::FIELD_MAX);
        end else begin
            if (w_fire) begin
                r_out_valid <= 1'b1;
                if (r_restart || (w_point < r_running)) begin
                    r_running <= w_point;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_fire) begin
            r_out_item.point_clearance <= w_point;
            r_out_item.overall_clearance <=
                (r_restart || (w_point < r_running)) ? w_point : r_running;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // The slot counter never runs past the active count while issuing.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sccm_pkg::ST_ISSUE) |-> (r_cnt < w_active))
        else $error("slot counter beyond active count");

    // Nothing leaves the root chain unless a query is walking its slots.
    a_tail_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctag[NCELL].valid |->
            (r_state == sccm_pkg::ST_ISSUE || r_state == sccm_pkg::ST_DRAIN))
        else $error("root chain output outside a query");

    // The overall clearance never exceeds the point clearance it came with.
    a_overall_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.overall_clearance <= o_out_item.point_clearance))
        else $error("overall clearance above point clearance");

    // A finished result is only launched when the output register is empty or its item is being taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(r_running) || !$past(w_fire))
        else $error("result launched over a waiting item");

endmodule
`default_nettype wire
